// ===== hdl/integer_to_ascii_formatter_macros.svh =====
// assertion macros for the integer to ascii formatter
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`ifndef SYNTHESIS
// antecedent in one cycle implies consequent in the same cycle
`define ITAF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// antecedent in one cycle implies consequent in the next cycle
`define ITAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ITAF_ASSERT_SAME(label, clk, rst, ante, cons)
`define ITAF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/itaf_pkg.sv =====
// shared types, codes and helpers of the integer to ascii formatter
package itaf_pkg;

   localparam int KIND_W = 3;
   localparam int VALUE_W = 64;
   localparam int CHAR_W = 8;
   localparam int COUNT_W = 31;
   localparam int PRE_N = 5;     // longest prefix: "(nil)"
   localparam int DIG_N = 16;    // longest digit string: 64-bit hex
   localparam int PLEN_W = 3;
   localparam int NDIG_W = 5;
   localparam int DIG_IDX_W = 4;

   localparam logic [KIND_W-1:0] KIND_CHAR = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SDEC = 3'd1;
   localparam logic [KIND_W-1:0] KIND_UDEC = 3'd2;
   localparam logic [KIND_W-1:0] KIND_HEXL = 3'd3;
   localparam logic [KIND_W-1:0] KIND_HEXU = 3'd4;
   localparam logic [KIND_W-1:0] KIND_PTR = 3'd5;

   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CH_X = 8'h78;
   localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CH_N = 8'h6E;
   localparam logic [CHAR_W-1:0] CH_I = 8'h69;
   localparam logic [CHAR_W-1:0] CH_L = 8'h6C;
   localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // ceil(2^35 / 10): floor(v * RECIP10 / 2^35) == v / 10 for every 32-bit v
   localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;
   localparam int RECIP10_SHIFT = 35;

   typedef struct packed {
      logic load;      // take a new request
      logic step;      // produce one digit
      logic advance;   // current character taken
   } itaf_cmd_type;

   typedef struct packed {
      logic bad_kind;   // request kind emits nothing
      logic no_digits;  // request is prefix only (char, nil pointer)
      logic conv_done;  // this step leaves a zero value
      logic emit_last;  // character on the output is the final one
   } itaf_stat_type;

   // ascii text of one digit value
   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
      logic [CHAR_W-1:0] base;
      base = upper ? CH_UPPER_A : CH_LOWER_A;
      if (d < 4'd10) begin
         return CH_ZERO + {4'b0, d};
      end else begin
         return base + {4'b0, d} - 8'd10;
      end
   endfunction

endpackage

// ===== hdl/itaf_ctrl.sv =====
// controller state machine of the integer to ascii formatter
module itaf_ctrl
   import itaf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  itaf_stat_type stat,
   output itaf_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (stat.bad_kind) begin
                  state_in = ST_IDLE;
               end else if (stat.no_digits) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            cmd.step = 1'b1;
            if (stat.conv_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.advance = 1'b1;
               if (stat.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/itaf_dp.sv =====
// datapath of the integer to ascii formatter: digit loop, buffers, count
module itaf_dp
   import itaf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [KIND_W-1:0]   req_type,
   input  logic [VALUE_W-1:0]  req_value,
   input  itaf_cmd_type        cmd,
   output itaf_stat_type       stat,
   output logic [CHAR_W-1:0]   rsp_char_out,
   output logic                rsp_last,
   output logic [COUNT_W-1:0]  rsp_total_count
);

   logic [VALUE_W-1:0] val_ff, val_in;
   logic               hex_ff, hex_in;
   logic               upper_ff, upper_in;
   logic [CHAR_W-1:0]  pre_ff [PRE_N];
   logic [CHAR_W-1:0]  pre_in [PRE_N];
   logic [PLEN_W-1:0]  plen_ff, plen_in;
   logic [CHAR_W-1:0]  dig_ff [DIG_N];
   logic [NDIG_W-1:0]  ndig_ff, ndig_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic [31:0]        w32;
   logic [31:0]        neg32;
   logic [63:0]        prod;
   logic [28:0]        quot;
   logic [31:0]        quot10;
   logic [3:0]         rem;
   logic [3:0]         digit;
   logic [VALUE_W-1:0] val_next;
   logic [NDIG_W-1:0]  ndig_dec;
   logic [NDIG_W-1:0]  remain;
   logic [COUNT_W-1:0] count_plus;

   // one digit a step: decimal by reciprocal multiply, hex by nibble shift
   assign prod = 64'(val_ff[31:0]) * 64'(RECIP10);
   assign quot = prod[63:RECIP10_SHIFT];
   assign quot10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
   assign rem = 4'(val_ff[31:0] - quot10);
   assign digit = hex_ff ? val_ff[3:0] : rem;
   assign val_next = hex_ff ? {4'b0, val_ff[VALUE_W-1:4]} : {35'b0, quot};

   assign w32 = req_value[31:0];
   assign neg32 = 32'(0) - w32;

   always_comb begin
      val_in = val_ff;
      hex_in = hex_ff;
      upper_in = upper_ff;
      plen_in = plen_ff;
      ndig_in = ndig_ff;
      for (int i = 0; i < PRE_N; i++) begin
         pre_in[i] = pre_ff[i];
      end
      if (cmd.load) begin
         ndig_in = '0;
         hex_in = 1'b0;
         upper_in = 1'b0;
         plen_in = '0;
         val_in = {32'b0, w32};
         unique case (req_type)
            KIND_CHAR: begin
               pre_in[0] = req_value[CHAR_W-1:0];
               plen_in = 3'd1;
            end
            KIND_SDEC: begin
               if (w32[31]) begin
                  pre_in[0] = CH_MINUS;
                  plen_in = 3'd1;
                  val_in = {32'b0, neg32};
               end
            end
            KIND_UDEC: begin
            end
            KIND_HEXL: begin
               hex_in = 1'b1;
            end
            KIND_HEXU: begin
               hex_in = 1'b1;
               upper_in = 1'b1;
            end
            KIND_PTR: begin
               hex_in = 1'b1;
               val_in = req_value;
               if (req_value == '0) begin
                  pre_in[0] = CH_LPAREN;
                  pre_in[1] = CH_N;
                  pre_in[2] = CH_I;
                  pre_in[3] = CH_L;
                  pre_in[4] = CH_RPAREN;
                  plen_in = 3'd5;
               end else begin
                  pre_in[0] = CH_ZERO;
                  pre_in[1] = CH_X;
                  plen_in = 3'd2;
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.step) begin
         val_in = val_next;
         ndig_in = ndig_ff + 5'd1;
      end else if (cmd.advance) begin
         if (plen_ff != '0) begin
            for (int i = 0; i < PRE_N - 1; i++) begin
               pre_in[i] = pre_ff[i+1];
            end
            plen_in = plen_ff - 3'd1;
         end else begin
            ndig_in = ndig_dec;
         end
      end
   end

   assign ndig_dec = ndig_ff - 5'd1;
   assign remain = {2'b00, plen_ff} + ndig_ff;
   assign count_plus = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 31'd1;
   assign count_in = cmd.advance ? count_plus : count_ff;

   // digits are stored least significant first and read back from the top
   assign rsp_char_out = (plen_ff != '0) ? pre_ff[0] : dig_ff[ndig_dec[DIG_IDX_W-1:0]];
   assign rsp_last = (remain == 5'd1);
   assign rsp_total_count = count_plus;

   assign stat.bad_kind = (req_type > KIND_PTR);
   assign stat.no_digits = (req_type == KIND_CHAR) ||
                           ((req_type == KIND_PTR) && (req_value == '0));
   assign stat.conv_done = (val_next == '0);
   assign stat.emit_last = rsp_last;

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      hex_ff <= hex_in;
      upper_ff <= upper_in;
      plen_ff <= plen_in;
      ndig_ff <= ndig_in;
      for (int i = 0; i < PRE_N; i++) begin
         pre_ff[i] <= pre_in[i];
      end
      if (cmd.step) begin
         dig_ff[ndig_ff[DIG_IDX_W-1:0]] <= digit_char(digit, upper_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/integer_to_ascii_formatter.sv =====
// top level of the integer to ascii formatter: %c %d %u %x %X %p conversion
// sequence: the request is taken, then the conversion loop produces one digit a step
//   (none for char and nil pointer, up to 10 decimal or 16 hex), then the characters go out
// throughput: one character per cycle while rsp_ready is held high; a new request is
//   taken only after the last character of the previous one, so requests do not overlap
// reset: synchronous active high, returns to idle and clears the running count
`include "integer_to_ascii_formatter_macros.svh"

module integer_to_ascii_formatter
   import itaf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KIND_W-1:0]   req_type,
   input  logic [VALUE_W-1:0]  req_value,
   // result channel, one character per transfer
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CHAR_W-1:0]   rsp_char_out,
   output logic                rsp_last,
   output logic [COUNT_W-1:0]  rsp_total_count
);

   // command and status between the state machine and the datapath
   itaf_cmd_type  cmd;
   itaf_stat_type stat;

   // sequencing: idle, digit conversion, character emission
   itaf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // value register, prefix and digit buffers, saturating character count
   itaf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_type),
      .req_value       (req_value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_char_out    (rsp_char_out),
      .rsp_last        (rsp_last),
      .rsp_total_count (rsp_total_count)
   );

   // a new request is never taken while characters are still pending
   `ITAF_ASSERT_SAME(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   // a taken character that is not the last keeps the output stream going
   `ITAF_ASSERT_NEXT(a_more_chars, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid)
   // after the last character the block is ready for the next request
   `ITAF_ASSERT_NEXT(a_back_idle, clock, reset, rsp_valid && rsp_ready && rsp_last, req_ready)

endmodule

// ===== sim/tb.sv =====
// testbench for integer_to_ascii_formatter: directed and random conversions checked per character
module tb
   import itaf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 12;
   localparam int MAX_WAIT = 13;
   localparam int DRAIN_CYCLES = 50;       // longer than the slowest unstalled request
   localparam int RANDOM_ITEMS = 200;
   localparam int MISMATCH_REPORTS = 10;
   localparam longint TIMEOUT_NS = 4_000_000;

   // request kinds that the block ignores
   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

   // one expected character on the result channel
   typedef struct packed {
      logic [CHAR_W-1:0]  ch;
      logic               last;
      logic [COUNT_W-1:0] count;
   } char_expect_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [KIND_W-1:0]  req_type = KIND_CHAR;
   logic [VALUE_W-1:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [CHAR_W-1:0]  rsp_char_out;
   logic               rsp_last;
   logic [COUNT_W-1:0] rsp_total_count;

   // predictor state: characters still owed by the block and the running count
   char_expect_type    pending_chars[$];
   logic [COUNT_W-1:0] predicted_total = '0;

   int fault_count = 0;
   int mismatch_count = 0;
   int send_calm = 0;
   int recv_calm = 0;

   integer_to_ascii_formatter uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_out    (rsp_char_out),
      .rsp_last        (rsp_last),
      .rsp_total_count (rsp_total_count)
   );

   always #4 clock = ~clock;

   // per-item idle draw, with occasional stretches of back-to-back traffic
   task automatic draw_wait(inout int calm, output int cycles);
      if (calm > 0) begin
         calm--;
         cycles = 0;
      end else begin
         cycles = $urandom_range(0, MAX_WAIT);
         if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(8, 24);
         end
      end
   endtask

   // expected characters of one accepted request, appended to pending_chars
   function automatic void predict_characters(input logic [KIND_W-1:0] kind,
                                              input logic [VALUE_W-1:0] value);
      logic [CHAR_W-1:0]  text[$];
      logic [CHAR_W-1:0]  digits[$];
      logic [VALUE_W-1:0] mag;
      logic [31:0]        neg;
      logic [3:0]         d;
      logic               upper;
      logic               has_digits;
      int                 radix;
      char_expect_type    item;
      has_digits = 1'b1;
      upper = 1'b0;
      radix = 10;
      mag = {32'b0, value[31:0]};
      case (kind)
         KIND_CHAR: begin
            has_digits = 1'b0;
            text.push_back(value[7:0]);
         end
         KIND_SDEC: begin
            // negative: minus sign, magnitude by unsigned negation (covers the most negative int)
            if (value[31]) begin
               text.push_back(CH_MINUS);
               neg = -value[31:0];
               mag = {32'b0, neg};
            end
         end
         KIND_UDEC: begin
         end
         KIND_HEXL: begin
            radix = 16;
         end
         KIND_HEXU: begin
            radix = 16;
            upper = 1'b1;
         end
         KIND_PTR: begin
            if (value == '0) begin
               has_digits = 1'b0;
               text.push_back(CH_LPAREN);
               text.push_back(CH_N);
               text.push_back(CH_I);
               text.push_back(CH_L);
               text.push_back(CH_RPAREN);
            end else begin
               text.push_back(CH_ZERO);
               text.push_back(CH_X);
               radix = 16;
               mag = value;
            end
         end
         default: begin
            has_digits = 1'b0;
         end
      endcase
      if (has_digits) begin
         // least significant digit first, so build the string from the front
         do begin
            d = 4'(mag % radix);
            if (d < 4'd10) begin
               digits.push_front(CH_ZERO + {4'b0, d});
            end else begin
               digits.push_front((upper ? CH_UPPER_A : CH_LOWER_A) + {4'b0, d} - 8'd10);
            end
            mag = mag / radix;
         end while (mag != '0);
         foreach (digits[i]) begin
            text.push_back(digits[i]);
         end
      end
      foreach (text[i]) begin
         if (predicted_total != COUNT_MAX) begin
            predicted_total = predicted_total + 1'b1;
         end
         item.ch = text[i];
         item.last = (i == text.size() - 1);
         item.count = predicted_total;
         pending_chars.push_back(item);
      end
   endfunction

   // one request: idle gap, then hold valid until the block takes it
   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
      int gap;
      draw_wait(send_calm, gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= kind;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      predict_characters(kind, value);
   endtask

   // stop sending until every expected character has come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_chars.size() != 0) @(posedge clock);
   endtask

   // operand mix: small numbers, sign and width corners, varied digit counts
   function automatic logic [VALUE_W-1:0] random_operand(input logic [KIND_W-1:0] kind);
      logic [VALUE_W-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: v[31:0] = $urandom_range(0, 20);
         1: begin
            case ($urandom_range(0, 5))
               0: v[31:0] = 32'h0000_0000;
               1: v[31:0] = 32'h7FFF_FFFF;
               2: v[31:0] = 32'h8000_0000;
               3: v[31:0] = 32'hFFFF_FFFF;
               4: v[31:0] = 32'h8000_0001;
               default: v[31:0] = 32'h0000_0010;
            endcase
         end
         2: v[31:0] = v[31:0] >> $urandom_range(0, 31);
         default: begin
         end
      endcase
      if (kind == KIND_PTR) begin
         case ($urandom_range(0, 4))
            0: v = '0;
            1: v = v >> $urandom_range(1, 63);
            default: begin
            end
         endcase
      end
      return v;
   endfunction

   // char kind: zero byte, all ones, junk in the upper bits
   task automatic test_char_kind();
      send_request(KIND_CHAR, 64'h0000_0000_0000_0000);
      send_request(KIND_CHAR, 64'h0000_0000_0000_00FF);
      send_request(KIND_CHAR, 64'hFFFF_FFFF_FFFF_FF41);
   endtask

   // signed decimal: zero, minus one, both extremes including the most negative int
   task automatic test_signed_decimal();
      send_request(KIND_SDEC, 64'h0000_0000_0000_0000);
      send_request(KIND_SDEC, 64'h1234_5678_FFFF_FFFF);
      send_request(KIND_SDEC, 64'h0000_0000_7FFF_FFFF);
      send_request(KIND_SDEC, 64'hFFFF_FFFF_8000_0000);
      send_request(KIND_SDEC, 64'h0000_0000_0000_3039);
   endtask

   // unsigned decimal: zero, full width, a ten-digit power of ten
   task automatic test_unsigned_decimal();
      send_request(KIND_UDEC, 64'hFFFF_FFFF_0000_0000);
      send_request(KIND_UDEC, 64'h0000_0000_FFFF_FFFF);
      send_request(KIND_UDEC, 64'h0000_0000_3B9A_CA00);
   endtask

   // hex in both cases, with leading zero suppression
   task automatic test_hex();
      send_request(KIND_HEXL, 64'h0000_0000_0000_0000);
      send_request(KIND_HEXL, 64'hAAAA_5555_DEAD_BEEF);
      send_request(KIND_HEXU, 64'h0000_0000_FFFF_FFFF);
      send_request(KIND_HEXU, 64'h0000_0000_000A_BCDE);
   endtask

   // pointers: nil, longest output, one digit, high bits only
   task automatic test_pointer();
      send_request(KIND_PTR, 64'h0000_0000_0000_0000);
      send_request(KIND_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(KIND_PTR, 64'h0000_0000_0000_0001);
      send_request(KIND_PTR, 64'h8000_0000_0000_0000);
      send_request(KIND_PTR, 64'h0000_0001_0000_0000);
   endtask

   // unused kinds produce nothing and leave the count alone
   task automatic test_unused_kinds();
      send_request(KIND_SPARE_A, 64'h0123_4567_89AB_CDEF);
      send_request(KIND_SPARE_B, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(KIND_UDEC, 64'h0000_0000_0000_0007);
   endtask

   // random kinds and operands, some ignored kinds mixed in as noise
   task automatic test_random_mix();
      int                 sent;
      logic [KIND_W-1:0]  kind;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 11) == 0) begin
            kind = ($urandom_range(0, 1) == 0) ? KIND_SPARE_A : KIND_SPARE_B;
         end else begin
            kind = KIND_CHAR + KIND_W'($urandom_range(0, KIND_PTR - KIND_CHAR));
            sent++;
         end
         send_request(kind, random_operand(kind));
         // one mid-run pause until the result side is empty
         if (sent == RANDOM_ITEMS / 2 && kind <= KIND_PTR) begin
            hold_until_drained();
         end
      end
   endtask

   // result side: random stalls, each accepted character checked in order
   initial begin : result_checker
      int              wait_cycles;
      char_expect_type want;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         draw_wait(recv_calm, wait_cycles);
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_chars.size() == 0) begin
            fault_count++;
            if (mismatch_count < MISMATCH_REPORTS) begin
               $display("unexpected character %h last %b count %0d",
                        rsp_char_out, rsp_last, rsp_total_count);
            end
            mismatch_count++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_char_out !== want.ch || rsp_last !== want.last ||
                rsp_total_count !== want.count) begin
               fault_count++;
               if (mismatch_count < MISMATCH_REPORTS) begin
                  $display("mismatch: char exp %h got %h, last exp %b got %b, count exp %0d got %0d",
                           want.ch, rsp_char_out, want.last, rsp_last,
                           want.count, rsp_total_count);
               end
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: far beyond the slowest legal run
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

   // test sequence
   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_char_kind();
      test_signed_decimal();
      test_unsigned_decimal();
      test_hex();
      test_pointer();
      test_unused_kinds();
      // let the block empty out before the random part
      hold_until_drained();
      test_random_mix();
      hold_until_drained();
      // an ignored request may still be inside the block
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_chars.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/itaf_pkg.sv
hdl/itaf_ctrl.sv
hdl/itaf_dp.sv
hdl/integer_to_ascii_formatter.sv
sim/tb.sv
